// File: rtl/wca_pkg.sv
// ----------------------------------------------------------------------------
// wca_pkg
// shared types, register indexes, status codes and counter mode helpers
// ----------------------------------------------------------------------------
package wca_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 24;

    typedef enum logic [CFG_AW-1:0] {
        CFG_CONV_MASK    = 3'd0,
        CFG_WIDE_MASK    = 3'd1,
        CFG_ABS_MASK     = 3'd2,
        CFG_SOFT_LIMIT   = 3'd3,
        CFG_HARD_LIMIT   = 3'd4,
        CFG_PRELOAD_VAL  = 3'd5,
        CFG_PRELOAD_MASK = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DISABLED = 3'd1,
        ST_RD_ERR   = 3'd2,
        ST_SOFT     = 3'd3,
        ST_STOPPED  = 3'd4
    } t_status;

    localparam logic signed [25:0] MIN16 = -26'sd32767;
    localparam logic signed [25:0] MAX16 = 26'sd32767;
    localparam logic signed [25:0] MOD16 = 26'sd65536;
    localparam logic signed [25:0] MIN24 = -26'sd8388607;
    localparam logic signed [25:0] MAX24 = 26'sd8388607;
    localparam logic signed [25:0] MOD24 = 26'sd16777216;

    // per channel state word
    typedef struct packed {
        logic [23:0]        old_val;
        logic signed [24:0] cur_val;
        logic [31:0]        acc;
    } t_entry;

    // one result item
    typedef struct packed {
        t_status            status;
        logic [15:0]        err_cnt;
        logic [31:0]        acc;
        logic signed [24:0] count;
        logic [1:0]         ch;
    } t_result;

    // reading in the channel's mode: 24-bit unsigned or 16-bit signed
    function automatic logic signed [24:0] as_mode(input logic [23:0] v, input logic wide);
        logic signed [24:0] r;
        if (wide) begin
            r = $signed({1'b0, v});
        end else begin
            r = $signed({{9{v[15]}}, v[15:0]});
        end
        return r;
    endfunction

endpackage

// File: rtl/wca_ram.sv
// ----------------------------------------------------------------------------
// wca_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module wca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/wca_out_fifo.sv
// ----------------------------------------------------------------------------
// wca_out_fifo
// three entry result queue between the update stage and the output stream
// ----------------------------------------------------------------------------
module wca_out_fifo
    import wca_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    input  logic       i_pop,
    output t_result    o_data,
    output logic       o_valid,
    output logic [1:0] o_count
);

    localparam int DEPTH = 3;

    t_result    r_mem [DEPTH];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [1:0] r_cnt;
    logic       pop_ok;

    assign pop_ok = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == 2'(DEPTH - 1)) ? 2'd0 : r_wp + 2'd1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == 2'(DEPTH - 1)) ? 2'd0 : r_rp + 2'd1;
            end
            case ({i_push, pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_count = r_cnt;

endmodule

// File: rtl/wrapping_counter_accumulator_unit.sv
// ----------------------------------------------------------------------------
// wrapping_counter_accumulator_unit
// per channel counter readings turned into wrap corrected accumulated totals
// ----------------------------------------------------------------------------
// path: an accepted item is registered in the input stage, then pushed into the result queue
// throughput: one item per cycle while input ready is high; state ram read in the accept cycle,
//   modified and written back in the next, with forwarding of the last write
// stalls: input ready drops once three items wait behind a stalled output
// reset: synchronous active low; registers return to defaults, per channel
//   first-reading flags make the state ram read as zero, no clearing pass
module wrapping_counter_accumulator_unit
    import wca_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // channel, raw_count, zero pad
    input  logic [1:0]        s_axis_tuser,  // read_error, fatal_error
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [79:0]       m_axis_tdata,  // out_channel, count_value,
                                             // absolute_value, error_count, zero pad
    output logic [2:0]        m_axis_tuser,  // status
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int NCH = (CHANNELS < 4) ? CHANNELS : 4;
    localparam int AW  = (NCH > 1) ? $clog2(NCH) : 1;

    // configuration
    logic [3:0]  r_conv_mask;
    logic [3:0]  r_wide_mask;
    logic [3:0]  r_abs_mask;
    logic [15:0] r_soft_limit;
    logic [15:0] r_hard_limit;
    logic [23:0] r_preload_val;
    logic [3:0]  r_preload_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_mask    <= 4'd15;
            r_wide_mask    <= 4'd15;
            r_abs_mask     <= 4'd0;
            r_soft_limit   <= 16'd100;
            r_hard_limit   <= 16'd1000;
            r_preload_val  <= 24'd0;
            r_preload_mask <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CONV_MASK:    r_conv_mask    <= i_cfg_data[3:0];
                CFG_WIDE_MASK:    r_wide_mask    <= i_cfg_data[3:0];
                CFG_ABS_MASK:     r_abs_mask     <= i_cfg_data[3:0];
                CFG_SOFT_LIMIT:   r_soft_limit   <= i_cfg_data[15:0];
                CFG_HARD_LIMIT:   r_hard_limit   <= i_cfg_data[15:0];
                CFG_PRELOAD_VAL:  r_preload_val  <= i_cfg_data;
                CFG_PRELOAD_MASK: r_preload_mask <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // input stage
    logic [1:0]    in_ch;
    logic          in_ok;
    logic [AW-1:0] in_idx;
    logic          in_acc;
    logic [1:0]    fifo_cnt;

    logic          r_s1_valid;
    logic [1:0]    r_s1_ch;
    logic          r_s1_ok;
    logic [AW-1:0] r_s1_idx;
    logic [23:0]   r_s1_raw;
    logic          r_s1_rderr;
    logic          r_s1_fatal;

    assign in_ch  = s_axis_tdata[1:0];
    assign in_ok  = (32'(in_ch) < CHANNELS);
    assign in_idx = in_ok ? in_ch[AW-1:0] : '0;

    assign s_axis_tready = ({1'b0, fifo_cnt} + {2'b0, r_s1_valid}) <= 3'd2;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ch    <= in_ch;
            r_s1_ok    <= in_ok;
            r_s1_idx   <= in_idx;
            r_s1_raw   <= s_axis_tdata[25:2];
            r_s1_rderr <= s_axis_tuser[0];
            r_s1_fatal <= s_axis_tuser[1];
        end
    end

    // state ram
    t_entry ram_rdata;
    t_entry wr_data;
    logic   wr_en;

    wca_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NCH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_idx),
        .i_wdata (wr_data),
        .i_re    (in_acc),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // update stage
    logic [NCH-1:0] r_first;
    logic           r_wb_valid;
    logic [AW-1:0]  r_wb_idx;
    t_entry         r_wb_data;
    logic [15:0]    r_err_cnt;
    logic           r_stopped;

    logic               first;
    t_entry             ent;
    logic               wide;
    logic               abs_en;
    logic signed [24:0] v;
    logic signed [24:0] old_m;
    logic signed [25:0] d_raw;
    logic signed [25:0] d;
    logic [31:0]        acc_base;
    logic [15:0]        err_inc;
    logic [15:0]        n_err_cnt;
    logic               n_stopped;
    t_status            status;
    t_result            res;

    always_comb begin
        first = r_first[r_s1_idx];
        if (first) begin
            ent = '0;
        end else if (r_wb_valid && (r_wb_idx == r_s1_idx)) begin
            ent = r_wb_data;
        end else begin
            ent = ram_rdata;
        end

        wide   = r_wide_mask[r_s1_ch];
        abs_en = r_abs_mask[r_s1_ch];
        v      = as_mode(r_s1_raw, wide);
        old_m  = as_mode(ent.old_val, wide);
        d_raw  = first ? 26'sd0 : (26'(v) - 26'(old_m));
        d      = d_raw;
        if (wide) begin
            if (d_raw < MIN24) begin
                d = d_raw + MOD24;
            end else if (d_raw > MAX24) begin
                d = d_raw - MOD24;
            end
        end else begin
            if (d_raw < MIN16) begin
                d = d_raw + MOD16;
            end else if (d_raw > MAX16) begin
                d = d_raw - MOD16;
            end
        end

        if (first) begin
            acc_base = r_preload_mask[r_s1_ch] ? {8'd0, r_preload_val} : 32'd0;
        end else begin
            acc_base = ent.acc;
        end

        err_inc   = (r_err_cnt == 16'hFFFF) ? r_err_cnt : r_err_cnt + 16'd1;
        n_err_cnt = r_err_cnt;
        n_stopped = r_stopped;
        wr_en     = 1'b0;
        wr_data   = ent;

        if (r_stopped) begin
            status = ST_STOPPED;
        end else if (r_s1_fatal) begin
            n_stopped = 1'b1;
            status    = ST_STOPPED;
        end else if (!r_s1_ok || !r_conv_mask[r_s1_ch]) begin
            status = ST_DISABLED;
        end else if (r_s1_rderr) begin
            n_err_cnt = err_inc;
            if (err_inc >= r_hard_limit) begin
                n_stopped = 1'b1;
                status    = ST_STOPPED;
            end else if (err_inc == r_soft_limit) begin
                status = ST_SOFT;
            end else begin
                status = ST_RD_ERR;
            end
        end else begin
            status          = ST_OK;
            wr_en           = r_s1_valid;
            wr_data.cur_val = v;
            wr_data.old_val = (abs_en || first) ? v[23:0] : ent.old_val;
            wr_data.acc     = abs_en ? (acc_base + 32'(d)) : acc_base;
        end

        res.ch      = r_s1_ch;
        res.status  = status;
        res.err_cnt = n_err_cnt;
        if (!r_s1_ok) begin
            res.count = '0;
            res.acc   = '0;
        end else if (status == ST_OK) begin
            res.count = wr_data.cur_val;
            res.acc   = wr_data.acc;
        end else begin
            res.count = ent.cur_val;
            res.acc   = ent.acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= '1;
            r_wb_valid <= 1'b0;
            r_err_cnt  <= '0;
            r_stopped  <= 1'b0;
        end else begin
            r_wb_valid <= wr_en;
            if (wr_en) begin
                r_first[r_s1_idx] <= 1'b0;
            end
            if (r_s1_valid) begin
                r_err_cnt <= n_err_cnt;
                r_stopped <= n_stopped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wb_idx  <= r_s1_idx;
            r_wb_data <= wr_data;
        end
    end

    // output queue
    t_result out_res;

    wca_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (res),
        .i_pop   (m_axis_tready),
        .o_data  (out_res),
        .o_valid (m_axis_tvalid),
        .o_count (fifo_cnt)
    );

    assign m_axis_tdata = {5'd0, out_res.err_cnt, out_res.acc, out_res.count, out_res.ch};
    assign m_axis_tuser = out_res.status;

    // checks
    a_fifo_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> fifo_cnt <= 2'd2)
        else $error("result queue overflow");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stop cleared without reset");

    a_err_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_err_cnt >= $past(r_err_cnt))
        else $error("error count went down");

    a_stopped_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_stopped) |-> (res.status == ST_STOPPED && !wr_en))
        else $error("item processed while stopped");

endmodule
